// ===== hdl/nnksb_pkg.sv =====
`timescale 1ns / 1ps
package nnksb_pkg;

    // Default build values and fixed field widths.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 8;
    localparam int ROW_LIMIT      = 1024;
    localparam int SIZE_W         = 11;
    localparam int ROW_W          = 10;
    localparam int ERR_W          = 13;
    localparam int CFG_ADDR_W     = 3;

    // Request codes of an input word.
    typedef enum logic [1:0] {
        REQ_XLAT = 2'd0,
        REQ_SRC  = 2'd1,
        REQ_TICK = 2'd2,
        REQ_PIX  = 2'd3
    } t_req;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_DST_WIDTH  = 3'd1,
        CFG_SRC_HEIGHT = 3'd2,
        CFG_DST_HEIGHT = 3'd3,
        CFG_KEY_MODE   = 3'd4,
        CFG_KEY_COLOR  = 3'd5
    } t_cfg_addr;

    // Effective (clamped) configuration seen by the datapath.
    typedef struct packed {
        logic [SIZE_W-1:0] src_width;
        logic [SIZE_W-1:0] dst_width;
        logic [SIZE_W-1:0] src_height;
        logic [SIZE_W-1:0] dst_height;
        logic              key_mode;
        logic [7:0]        key_color;
    } t_cfg;

    // One queued request word.
    typedef struct packed {
        t_req       op;
        logic [7:0] pixel;
        logic [7:0] xlat_index;
        logic [7:0] xlat_value;
    } t_item;

    // One result word.
    typedef struct packed {
        logic             out_kind;
        logic [7:0]       out_pixel;
        logic [ROW_W-1:0] src_row;
        logic [ROW_W-1:0] dest_row;
        logic             row_new;
        logic             in_range;
        logic             last_in_row;
    } t_result;

    // Precomputed Bresenham step: quotient and remainder of source by destination size.
    typedef struct packed {
        logic              busy;
        logic [SIZE_W-1:0] q_w;
        logic [SIZE_W-1:0] r_w;
        logic [SIZE_W-1:0] q_h;
        logic [SIZE_W-1:0] r_h;
    } t_step;

    // A size of zero acts as one; sizes above the limit act as the limit.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                      input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] res;
        if (v == '0) begin
            res = SIZE_W'(1);
        end else if (v > lim) begin
            res = lim;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== hdl/nnksb_if.sv =====
`timescale 1ns / 1ps
// Request channel.
interface nnksb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] pixel;
    logic [7:0] xlat_index;
    logic [7:0] xlat_value;
    modport source (output valid, req_type, pixel, xlat_index, xlat_value, input ready);
    modport sink (input valid, req_type, pixel, xlat_index, xlat_value, output ready);
endinterface

// Result channel.
interface nnksb_out_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] out_pixel;
    logic [9:0] src_row;
    logic [9:0] dest_row;
    logic       row_new;
    logic       in_range;
    logic       last_in_row;
    modport source (output valid, out_kind, out_pixel, src_row, dest_row, row_new,
                    in_range, last_in_row, input ready);
    modport sink (input valid, out_kind, out_pixel, src_row, dest_row, row_new,
                  in_range, last_in_row, output ready);
endinterface

// Configuration write channel.
interface nnksb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  addr;
    logic [10:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

// ===== hdl/nnksb_front.sv =====
`timescale 1ns / 1ps
module nnksb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    nnksb_in_if.sink       i_px,
    output nnksb_pkg::t_item o_item,
    output logic           o_item_valid,
    input  logic           i_item_pop
);
    import nnksb_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    t_item      w_item;

    // Classify the incoming word into a queue entry.
    always_comb begin
        w_item.op         = t_req'(i_px.req_type);
        w_item.pixel      = i_px.pixel;
        w_item.xlat_index = i_px.xlat_index;
        w_item.xlat_value = i_px.xlat_value;
    end

    assign i_px.ready   = (r_cnt != 2'd2);
    assign w_push       = i_px.valid && i_px.ready;
    assign o_item       = r_q[r_rp];
    assign o_item_valid = (r_cnt != 2'd0);

    // Two-entry queue toward the back end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_item_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_item_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

// ===== hdl/nnksb_div.sv =====
`timescale 1ns / 1ps
module nnksb_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [nnksb_pkg::SIZE_W-1:0]   i_num,
    input  logic [nnksb_pkg::SIZE_W-1:0]   i_den,
    output logic                           o_busy,
    output logic [nnksb_pkg::SIZE_W-1:0]   o_quo,
    output logic [nnksb_pkg::SIZE_W-1:0]   o_rem
);
    import nnksb_pkg::*;

    localparam int CNT_W = $clog2(SIZE_W + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [SIZE_W-1:0] r_quo, n_quo;
    logic [SIZE_W-1:0] r_rem, n_rem;
    logic [SIZE_W:0]   w_trial;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb begin
        w_trial = {r_rem, r_quo[SIZE_W-1]};
        if (w_trial >= {1'b0, i_den}) begin
            n_rem = SIZE_W'(w_trial - {1'b0, i_den});
            n_quo = {r_quo[SIZE_W-2:0], 1'b1};
        end else begin
            n_rem = SIZE_W'(w_trial);
            n_quo = {r_quo[SIZE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(SIZE_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy || i_start;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/nnksb_back.sv =====
`timescale 1ns / 1ps
module nnksb_back #(
    parameter int MAX_WIDTH  = nnksb_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = nnksb_pkg::PIXEL_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nnksb_pkg::t_cfg    i_cfg,
    input  logic               i_restart,
    input  nnksb_pkg::t_step   i_step,
    input  nnksb_pkg::t_item   i_item,
    input  logic               i_item_valid,
    output logic               o_item_pop,
    output nnksb_pkg::t_result o_res,
    output logic               o_res_valid,
    input  logic               i_res_ready
);
    import nnksb_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int PB    = PIXEL_BITS;
    localparam int XDEP  = 2 ** PIXEL_BITS;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD1  = 4'b0010,
        ST_RD2  = 4'b0100,
        ST_NORM = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Line stores and translation table.
    logic [PB-1:0] r_src_line  [MAX_WIDTH];
    logic [PB-1:0] r_comp_line [MAX_WIDTH];
    logic [PB-1:0] r_xlat      [XDEP];
    logic [PB-1:0] r_src_q, r_comp_q, r_xlat_q;

    // Scan state.
    logic [SIZE_W-1:0]       r_load_pos, r_dest_col, r_src_col, r_cur_row, r_rows_done;
    logic [SIZE_W-1:0]       r_prev_row;
    logic signed [ERR_W-1:0] r_col_err, r_row_err;
    logic                    r_prev_valid, r_row_repeat, r_norm_row;
    t_item                   r_item;
    t_result                 r_res;
    logic                    r_res_valid;

    logic                    w_out_free, w_pop, w_emit;
    t_result                 w_res;
    logic                    w_src_wr, w_comp_wr;
    logic [PB-1:0]           w_pix_res;
    logic signed [ERR_W-1:0] w_col_init, w_row_init;
    logic signed [ERR_W-1:0] w_err, w_d, w_r, w_less;
    logic [SIZE_W-1:0]       w_q;
    logic                    w_tick_inr, w_fresh, w_pix_inr;

    assign w_out_free = !r_res_valid || i_res_ready;

    assign w_col_init = $signed({2'b00, i_cfg.dst_width})
                      - $signed({3'b000, i_cfg.src_width[SIZE_W-1:1]});
    assign w_row_init = $signed({2'b00, i_cfg.dst_height})
                      - $signed({3'b000, i_cfg.src_height[SIZE_W-1:1]});

    assign w_tick_inr = (r_rows_done < i_cfg.dst_height);
    assign w_fresh    = !r_prev_valid || (r_cur_row != r_prev_row);
    assign w_pix_inr  = (r_dest_col < i_cfg.dst_width);

    // Take a word when idle with no division busy; result words need a free output slot.
    always_comb begin
        w_pop = 1'b0;
        if (r_state == ST_IDLE && i_item_valid && !i_step.busy && !i_restart) begin
            case (i_item.op)
                REQ_XLAT, REQ_SRC: w_pop = 1'b1;
                default:           w_pop = w_out_free;
            endcase
        end
    end
    assign o_item_pop = w_pop;

    // Composition of one destination pixel; keyed only when key mode is on.
    always_comb begin
        if (i_cfg.key_mode) begin
            if (r_row_repeat) begin
                w_pix_res = r_comp_q;
            end else if (16'(r_src_q) == 16'(i_cfg.key_color)) begin
                w_pix_res = PB'(r_item.pixel);
            end else begin
                w_pix_res = r_xlat_q;
            end
        end else begin
            w_pix_res = r_src_q;
        end
    end

    // Result word assembly.
    always_comb begin
        w_emit = 1'b0;
        w_res  = '0;
        if (w_pop && i_item.op == REQ_TICK) begin
            w_emit       = 1'b1;
            w_res.src_row  = ROW_W'(r_cur_row);
            w_res.dest_row = ROW_W'(r_rows_done);
            w_res.row_new  = w_tick_inr && w_fresh;
            w_res.in_range = w_tick_inr;
        end else if (w_pop && i_item.op == REQ_PIX && !w_pix_inr) begin
            w_emit         = 1'b1;
            w_res.out_kind = 1'b1;
            w_res.out_pixel = i_item.pixel;
            w_res.src_row  = ROW_W'(r_prev_row);
            w_res.dest_row = ROW_W'((r_rows_done == '0) ? r_rows_done
                                                          : r_rows_done - SIZE_W'(1));
        end else if (r_state == ST_RD2) begin
            w_emit          = 1'b1;
            w_res.out_kind  = 1'b1;
            w_res.out_pixel = 8'(w_pix_res);
            w_res.src_row   = ROW_W'(r_prev_row);
            w_res.dest_row  = ROW_W'((r_rows_done == '0) ? r_rows_done
                                                           : r_rows_done - SIZE_W'(1));
            w_res.in_range  = 1'b1;
            w_res.last_in_row = (r_dest_col == i_cfg.dst_width - SIZE_W'(1));
        end
    end

    assign w_src_wr  = w_pop && i_item.op == REQ_SRC && r_load_pos < i_cfg.src_width;
    assign w_comp_wr = (r_state == ST_RD2) && !(r_row_repeat && i_cfg.key_mode);

    // Step operands for the axis being advanced.
    always_comb begin
        if (r_norm_row) begin
            w_err = r_row_err;
            w_d   = $signed({2'b00, i_cfg.dst_height});
            w_r   = $signed({2'b00, i_step.r_h});
            w_q   = i_step.q_h;
        end else begin
            w_err = r_col_err;
            w_d   = $signed({2'b00, i_cfg.dst_width});
            w_r   = $signed({2'b00, i_step.r_w});
            w_q   = i_step.q_w;
        end
        w_less = w_err - w_r;
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_pop && i_item.op == REQ_PIX && w_pix_inr) begin
                    n_state = ST_RD1;
                end else if (w_pop && i_item.op == REQ_TICK && w_tick_inr) begin
                    n_state = ST_NORM;
                end
            end
            ST_RD1:  n_state = ST_RD2;
            ST_RD2:  n_state = ST_NORM;
            ST_NORM: begin
                if (w_err > 0) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_res_valid  <= 1'b0;
            r_load_pos   <= '0;
            r_dest_col   <= '0;
            r_src_col    <= '0;
            r_cur_row    <= '0;
            r_rows_done  <= '0;
            r_prev_row   <= '0;
            r_prev_valid <= 1'b0;
            r_row_repeat <= 1'b0;
            r_norm_row   <= 1'b0;
            r_col_err    <= '0;
            r_row_err    <= '0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end

            if (i_restart) begin
                // Frame restart after reset or a size change.
                r_load_pos   <= '0;
                r_dest_col   <= '0;
                r_src_col    <= '0;
                r_col_err    <= w_col_init;
                r_cur_row    <= '0;
                r_rows_done  <= '0;
                r_prev_row   <= '0;
                r_prev_valid <= 1'b0;
                r_row_repeat <= 1'b0;
                r_row_err    <= w_row_init;
            end else begin
                if (w_src_wr) begin
                    r_load_pos <= r_load_pos + SIZE_W'(1);
                end
                if (w_pop && i_item.op == REQ_TICK && w_tick_inr) begin
                    r_prev_valid <= 1'b1;
                    r_prev_row   <= r_cur_row;
                    r_row_repeat <= !w_fresh;
                    r_rows_done  <= r_rows_done + SIZE_W'(1);
                    r_load_pos   <= '0;
                    r_dest_col   <= '0;
                    r_src_col    <= '0;
                    r_col_err    <= w_col_init;
                    r_norm_row   <= 1'b1;
                end
                if (r_state == ST_RD2) begin
                    r_dest_col <= r_dest_col + SIZE_W'(1);
                    r_norm_row <= 1'b0;
                end
                // Bresenham step: first lift a non-positive error, then take the
                // precomputed quotient step with one remainder correction.
                if (r_state == ST_NORM) begin
                    if (r_norm_row) begin
                        if (w_err <= 0) begin
                            r_row_err <= w_err + w_d;
                            r_cur_row <= r_cur_row + SIZE_W'(1);
                        end else if (w_less > 0) begin
                            r_row_err <= w_less;
                            r_cur_row <= r_cur_row + w_q;
                        end else begin
                            r_row_err <= w_less + w_d;
                            r_cur_row <= r_cur_row + w_q + SIZE_W'(1);
                        end
                    end else begin
                        if (w_err <= 0) begin
                            r_col_err <= w_err + w_d;
                            r_src_col <= r_src_col + SIZE_W'(1);
                        end else if (w_less > 0) begin
                            r_col_err <= w_less;
                            r_src_col <= r_src_col + w_q;
                        end else begin
                            r_col_err <= w_less + w_d;
                            r_src_col <= r_src_col + w_q + SIZE_W'(1);
                        end
                    end
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_item <= i_item;
        end
        if (w_emit) begin
            r_res <= w_res;
        end
    end

    // Source line store.
    always_ff @(posedge i_clk) begin
        if (w_src_wr) begin
            r_src_line[AW'(r_load_pos)] <= PB'(i_item.pixel);
        end
        r_src_q <= r_src_line[AW'(r_src_col)];
    end

    // Composite line store.
    always_ff @(posedge i_clk) begin
        if (w_comp_wr) begin
            r_comp_line[AW'(r_dest_col)] <= w_pix_res;
        end
        r_comp_q <= r_comp_line[AW'(r_dest_col)];
    end

    // Translation table.
    always_ff @(posedge i_clk) begin
        if (w_pop && i_item.op == REQ_XLAT) begin
            r_xlat[PB'(i_item.xlat_index)] <= PB'(i_item.xlat_value);
        end
        r_xlat_q <= r_xlat[r_src_q];
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

endmodule

// ===== hdl/nearest_neighbor_keyed_scale_blit.sv =====
`timescale 1ns / 1ps
// Translation and source words are taken while idle; a row tick in range then runs the
// row step. A pixel request in range goes through the read states RD1 and RD2, then
// the column step, which adds the destination size again while its error is not positive.
// A size write blocks words while the step quotients are recomputed.
// Reset is synchronous, active low; after reset the same computation runs.
module nearest_neighbor_keyed_scale_blit #(
    parameter int MAX_WIDTH  = nnksb_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = nnksb_pkg::PIXEL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nnksb_in_if.sink    i_px,
    nnksb_out_if.source o_res,
    nnksb_cfg_if.sink   i_cfg
);
    import nnksb_pkg::*;

    localparam logic [SIZE_W-1:0] WLIM = (MAX_WIDTH > 2047) ? SIZE_W'(2047)
                                                            : SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HLIM = SIZE_W'(ROW_LIMIT);

    logic [SIZE_W-1:0] r_src_w, r_dst_w, r_src_h, r_dst_h;
    logic              r_key_mode;
    logic [7:0]        r_key_color;
    logic              r_kick;
    logic              w_cfg_wr, w_size_wr;
    t_cfg              w_cfg;
    t_step             w_step;
    t_item             w_item;
    logic              w_item_valid, w_item_pop;
    t_result           w_res;
    logic              w_bw, w_bh;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr    = i_cfg.valid && i_cfg.ready;

    always_comb begin
        case (t_cfg_addr'(i_cfg.addr))
            CFG_SRC_WIDTH, CFG_DST_WIDTH, CFG_SRC_HEIGHT, CFG_DST_HEIGHT:
                w_size_wr = w_cfg_wr;
            default: w_size_wr = 1'b0;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w     <= SIZE_W'(1);
            r_dst_w     <= SIZE_W'(1);
            r_src_h     <= SIZE_W'(1);
            r_dst_h     <= SIZE_W'(1);
            r_key_mode  <= 1'b0;
            r_key_color <= '0;
            r_kick      <= 1'b1;
        end else begin
            r_kick <= w_size_wr;
            if (w_cfg_wr) begin
                case (t_cfg_addr'(i_cfg.addr))
                    CFG_SRC_WIDTH:  r_src_w     <= i_cfg.data;
                    CFG_DST_WIDTH:  r_dst_w     <= i_cfg.data;
                    CFG_SRC_HEIGHT: r_src_h     <= i_cfg.data;
                    CFG_DST_HEIGHT: r_dst_h     <= i_cfg.data;
                    CFG_KEY_MODE:   r_key_mode  <= i_cfg.data[0];
                    CFG_KEY_COLOR:  r_key_color <= i_cfg.data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // Effective sizes.
    always_comb begin
        w_cfg.src_width  = clamp_size(r_src_w, WLIM);
        w_cfg.dst_width  = clamp_size(r_dst_w, WLIM);
        w_cfg.src_height = clamp_size(r_src_h, HLIM);
        w_cfg.dst_height = clamp_size(r_dst_h, HLIM);
        w_cfg.key_mode   = r_key_mode;
        w_cfg.key_color  = r_key_color;
    end

    nnksb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_px         (i_px),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_item_pop   (w_item_pop)
    );

    // Step quotients for both axes.
    nnksb_div u_div_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick),
        .i_num   (w_cfg.src_width),
        .i_den   (w_cfg.dst_width),
        .o_busy  (w_bw),
        .o_quo   (w_step.q_w),
        .o_rem   (w_step.r_w)
    );

    nnksb_div u_div_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_kick),
        .i_num   (w_cfg.src_height),
        .i_den   (w_cfg.dst_height),
        .o_busy  (w_bh),
        .o_quo   (w_step.q_h),
        .o_rem   (w_step.r_h)
    );

    assign w_step.busy = w_bw || w_bh;

    nnksb_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_restart    (r_kick),
        .i_step       (w_step),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_item_pop   (w_item_pop),
        .o_res        (w_res),
        .o_res_valid  (o_res.valid),
        .i_res_ready  (o_res.ready)
    );

    assign o_res.out_kind    = w_res.out_kind;
    assign o_res.out_pixel   = w_res.out_pixel;
    assign o_res.src_row     = w_res.src_row;
    assign o_res.dest_row    = w_res.dest_row;
    assign o_res.row_new     = w_res.row_new;
    assign o_res.in_range    = w_res.in_range;
    assign o_res.last_in_row = w_res.last_in_row;

endmodule

// ===== test/tb_nearest_neighbor_keyed_scale_blit.sv =====
`timescale 1ns / 1ps
module tb_nearest_neighbor_keyed_scale_blit;
    import nnksb_pkg::*;

    localparam int MAXW       = 1024;
    localparam int WATCH_MAX  = 8000;
    localparam int LONG_HOLD  = 300;
    localparam int DRAIN_WAIT = 600;
    localparam int ITEM_GOAL  = 650;

    logic i_clk;
    logic i_rst_n;

    nnksb_in_if  px_ch();
    nnksb_out_if res_ch();
    nnksb_cfg_if cfg_ch();

    nearest_neighbor_keyed_scale_blit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_px    (px_ch.sink),
        .o_res   (res_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Clock with a 12 ns period.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Words waiting to be driven and results still owed by the block.
    t_item   word_q[$];
    t_result owed_q[$];

    // Scaler state as the block should hold it.
    int  src_w, dst_w, src_h, dst_h;
    bit  key_on;
    int  key_val;
    int  line_pix[MAXW];
    int  comp_pix[MAXW];
    int  xlat_map[256];
    bit  line_ok[MAXW];
    bit  comp_ok[MAXW];
    bit  xlat_ok[256];
    int  load_pos, dest_col, src_col, cur_row, rows_done, prev_row;
    int  col_err, row_err;
    bit  prev_ok, row_again;

    bit  failed;
    bit  calm;
    bit  stall_req, stall_done;
    int  hold_left, rx_gap, tx_gap;
    bit  px_taken, cfg_taken;
    int  idle_cycles;
    int  sent;

    function automatic int eff_size(input int v);
        if (v == 0) return 1;
        return (v > MAXW) ? MAXW : v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (calm || r < 10) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Bresenham step: drop by the source size, then add the destination size until positive.
    task automatic bres_advance(inout int err, inout int pos, input int s, input int d);
        int e;
        int k;
        e = err - s;
        if (e <= 0) begin
            k = (-e) / d + 1;
            e += k * d;
            pos += k;
        end
        err = e;
    endtask

    task automatic restart_line();
        load_pos = 0;
        dest_col = 0;
        src_col  = 0;
        col_err  = eff_size(dst_w) - (eff_size(src_w) >> 1);
    endtask

    task automatic restart_frame();
        restart_line();
        cur_row   = 0;
        rows_done = 0;
        prev_row  = 0;
        prev_ok   = 1'b0;
        row_again = 1'b0;
        row_err   = eff_size(dst_h) - (eff_size(src_h) >> 1);
    endtask

    task automatic blit_cfg(input t_cfg_addr a, input logic [10:0] d);
        case (a)
            CFG_SRC_WIDTH: begin
                src_w = d;
                restart_frame();
            end
            CFG_DST_WIDTH: begin
                dst_w = d;
                restart_frame();
            end
            CFG_SRC_HEIGHT: begin
                src_h = d;
                restart_frame();
            end
            CFG_DST_HEIGHT: begin
                dst_h = d;
                restart_frame();
            end
            CFG_KEY_MODE: key_on = d[0];
            CFG_KEY_COLOR: key_val = d[7:0];
            default: ;
        endcase
    endtask

    // True when a pixel request now reads only store entries already written.
    function automatic bit pix_readable();
        int p;
        if (dest_col >= eff_size(dst_w)) return 1'b1;
        if (row_again && key_on) return comp_ok[dest_col];
        if (src_col >= MAXW || !line_ok[src_col]) return 1'b0;
        p = line_pix[src_col];
        if (key_on && p != key_val) return xlat_ok[p];
        return 1'b1;
    endfunction

    // Work out the effect of one word and queue its result, if it gives one.
    task automatic blit_predict(input t_item w);
        t_result r;
        bit      fresh;
        int      dw;
        int      p;
        int      v;
        r = '0;
        dw = eff_size(dst_w);
        case (w.op)
            REQ_XLAT: begin
                xlat_map[w.xlat_index] = w.xlat_value;
                xlat_ok[w.xlat_index]  = 1'b1;
            end
            REQ_SRC: begin
                if (load_pos < eff_size(src_w)) begin
                    line_pix[load_pos] = w.pixel;
                    line_ok[load_pos]  = 1'b1;
                    load_pos++;
                end
            end
            REQ_TICK: begin
                r.src_row  = cur_row[9:0];
                r.dest_row = rows_done[9:0];
                fresh = 1'b0;
                if (rows_done < eff_size(dst_h)) begin
                    fresh     = !prev_ok || cur_row != prev_row;
                    prev_ok   = 1'b1;
                    prev_row  = cur_row;
                    row_again = !fresh;
                    rows_done++;
                    bres_advance(row_err, cur_row, eff_size(src_h), eff_size(dst_h));
                    restart_line();
                    r.in_range = 1'b1;
                end
                r.row_new = fresh;
                owed_q.push_back(r);
            end
            default: begin
                r.out_kind = 1'b1;
                r.src_row  = prev_row[9:0];
                r.dest_row = (rows_done == 0) ? 10'd0 : 10'(rows_done - 1);
                if (dest_col >= dw) begin
                    r.out_pixel = w.pixel;
                end else begin
                    if (row_again && key_on) begin
                        v = comp_pix[dest_col];
                    end else begin
                        p = line_pix[src_col];
                        if (key_on) v = (p == key_val) ? w.pixel : xlat_map[p];
                        else v = p;
                        comp_pix[dest_col] = v;
                        comp_ok[dest_col]  = 1'b1;
                    end
                    r.out_pixel   = v[7:0];
                    r.in_range    = 1'b1;
                    r.last_in_row = (dest_col == dw - 1);
                    dest_col++;
                    bres_advance(col_err, src_col, eff_size(src_w), dw);
                end
                owed_q.push_back(r);
            end
        endcase
    endtask

    // Queue one word; a pixel request that would read an unwritten entry is dropped.
    task automatic send_word(input t_req op, input int pix, input int xi, input int xv);
        t_item w;
        if (op == REQ_PIX && !pix_readable()) return;
        w.op         = op;
        w.pixel      = pix[7:0];
        w.xlat_index = xi[7:0];
        w.xlat_value = xv[7:0];
        blit_predict(w);
        word_q.push_back(w);
        sent++;
    endtask

    task automatic wait_idle();
        while (word_q.size() != 0 || owed_q.size() != 0 || px_ch.valid) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_addr a, input logic [10:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= a;
        cfg_ch.data  <= d;
        @(negedge i_clk);
        while (!cfg_taken) @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        blit_cfg(a, d);
    endtask

    task automatic set_all(input int sw, input int dw, input int sh, input int dh,
                           input bit km, input int kc);
        wait_idle();
        cfg_write(CFG_SRC_WIDTH, sw[10:0]);
        cfg_write(CFG_DST_WIDTH, dw[10:0]);
        cfg_write(CFG_SRC_HEIGHT, sh[10:0]);
        cfg_write(CFG_DST_HEIGHT, dh[10:0]);
        cfg_write(CFG_KEY_MODE, {10'd0, km});
        cfg_write(CFG_KEY_COLOR, kc[10:0]);
    endtask

    // One well-formed row: tick, source line, destination requests, with some noise if noisy.
    task automatic gen_row(input bit noisy);
        int n;
        int pv;
        send_word(REQ_TICK, $urandom_range(0, 255), 0, 0);
        n = eff_size(src_w) + ((noisy && $urandom_range(0, 3) == 0) ? 2 : 0);
        for (int i = 0; i < n; i++) begin
            pv = ($urandom_range(0, 3) == 0) ? key_val : $urandom_range(0, 255);
            send_word(REQ_SRC, pv, 0, 0);
            if (noisy && $urandom_range(0, 15) == 0)
                send_word(REQ_XLAT, 0, $urandom_range(0, 255), $urandom_range(0, 255));
        end
        n = eff_size(dst_w) + ((noisy && $urandom_range(0, 3) == 0) ? 1 : 0);
        for (int i = 0; i < n; i++) begin
            send_word(REQ_PIX, $urandom_range(0, 255), 0, 0);
            if (noisy && $urandom_range(0, 31) == 0)
                send_word(REQ_TICK, 0, 0, 0);
        end
    endtask

    // Sample the handshakes at the rising edge.
    always @(posedge i_clk) begin
        px_taken  <= px_ch.valid && px_ch.ready;
        cfg_taken <= cfg_ch.valid && cfg_ch.ready;
    end

    // Word driver, fed from the pending queue.
    always @(negedge i_clk) begin : drive_words
        t_item w;
        if (!i_rst_n) begin
            px_ch.valid <= 1'b0;
            tx_gap      <= 0;
        end else if (px_ch.valid && !px_taken) begin
            // Word still offered.
        end else if (tx_gap > 0) begin
            px_ch.valid <= 1'b0;
            tx_gap      <= tx_gap - 1;
        end else if (word_q.size() != 0) begin
            w = word_q.pop_front();
            px_ch.valid      <= 1'b1;
            px_ch.req_type   <= w.op;
            px_ch.pixel      <= w.pixel;
            px_ch.xlat_index <= w.xlat_index;
            px_ch.xlat_value <= w.xlat_value;
            tx_gap           <= pick_gap();
        end else begin
            px_ch.valid <= 1'b0;
        end
    end

    // Result receiver with random stalls and one long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            hold_left    <= 0;
            rx_gap       <= 0;
        end else if (hold_left > 0) begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (stall_req && !stall_done) begin
            res_ch.ready <= 1'b0;
            hold_left    <= LONG_HOLD;
            stall_done   <= 1'b1;
        end else if (rx_gap > 0) begin
            res_ch.ready <= 1'b0;
            rx_gap       <= rx_gap - 1;
        end else begin
            res_ch.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) rx_gap <= pick_gap();
        end
    end

    // Result checker and watchdog.
    always @(posedge i_clk) begin : check_results
        t_result e;
        if (i_rst_n) begin
            if ((px_ch.valid && px_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
                    || (res_ch.valid && res_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCH_MAX) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (res_ch.valid && res_ch.ready) begin
                if (owed_q.size() == 0) begin
                    $error("result word with nothing owed");
                    failed <= 1'b1;
                end else begin
                    e = owed_q.pop_front();
                    if (res_ch.out_kind !== e.out_kind) begin
                        $error("out_kind exp %0d got %0d", e.out_kind, res_ch.out_kind);
                        failed <= 1'b1;
                    end
                    if (res_ch.out_pixel !== e.out_pixel) begin
                        $error("out_pixel exp %0d got %0d", e.out_pixel, res_ch.out_pixel);
                        failed <= 1'b1;
                    end
                    if (res_ch.src_row !== e.src_row) begin
                        $error("src_row exp %0d got %0d", e.src_row, res_ch.src_row);
                        failed <= 1'b1;
                    end
                    if (res_ch.dest_row !== e.dest_row) begin
                        $error("dest_row exp %0d got %0d", e.dest_row, res_ch.dest_row);
                        failed <= 1'b1;
                    end
                    if (res_ch.row_new !== e.row_new) begin
                        $error("row_new exp %0d got %0d", e.row_new, res_ch.row_new);
                        failed <= 1'b1;
                    end
                    if (res_ch.in_range !== e.in_range) begin
                        $error("in_range exp %0d got %0d", e.in_range, res_ch.in_range);
                        failed <= 1'b1;
                    end
                    if (res_ch.last_in_row !== e.last_in_row) begin
                        $error("last_in_row exp %0d got %0d", e.last_in_row,
                               res_ch.last_in_row);
                        failed <= 1'b1;
                    end
                end
            end
        end
    end

    // Stimulus: directed corners first, then random rows.
    initial begin
        int lim;
        px_ch.valid      = 1'b0;
        px_ch.req_type   = REQ_XLAT;
        px_ch.pixel      = '0;
        px_ch.xlat_index = '0;
        px_ch.xlat_value = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.addr      = CFG_SRC_WIDTH;
        cfg_ch.data      = '0;
        res_ch.ready     = 1'b0;
        failed      = 1'b0;
        calm        = 1'b0;
        stall_req   = 1'b0;
        stall_done  = 1'b0;
        idle_cycles = 0;
        px_taken    = 1'b0;
        cfg_taken   = 1'b0;
        sent        = 0;
        src_w = 1; dst_w = 1; src_h = 1; dst_h = 1;
        key_on = 1'b0; key_val = 0;
        foreach (line_ok[i]) begin
            line_ok[i] = 1'b0;
            comp_ok[i] = 1'b0;
        end
        foreach (xlat_ok[i]) xlat_ok[i] = 1'b0;
        restart_frame();
        i_rst_n = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the translation table, covering every index and value bit.
        for (int i = 0; i < 256; i++) send_word(REQ_XLAT, 0, i, 255 - i);

        // Zero sizes act as one; an extra tick runs past the height.
        set_all(0, 0, 0, 0, 1'b0, 0);
        gen_row(1'b0);
        send_word(REQ_PIX, 8'hA5, 0, 0);
        send_word(REQ_TICK, 0, 0, 0);
        send_word(REQ_PIX, 8'h5A, 0, 0);

        // Upscale in key mode with repeated rows, under a long receiver hold-off.
        set_all(4, 7, 3, 5, 1'b1, 8'hFF);
        stall_req = 1'b1;
        repeat (6) gen_row(1'b1);

        // Downscale in key mode, past the height.
        set_all(7, 3, 5, 2, 1'b1, 8'h00);
        repeat (3) gen_row(1'b1);

        // Sizes above the limit act as the limit; short partial rows, no idling.
        calm = 1'b1;
        set_all(2047, 5, 2047, 1, 1'b0, 8'h80);
        send_word(REQ_TICK, 0, 0, 0);
        for (int i = 0; i < 6; i++) send_word(REQ_SRC, $urandom_range(0, 255), 0, 0);
        for (int i = 0; i < 6; i++) send_word(REQ_PIX, $urandom_range(0, 255), 0, 0);
        send_word(REQ_TICK, 0, 0, 0);
        set_all(5, 2047, 1, 2047, 1'b1, 8'h7F);
        send_word(REQ_TICK, 0, 0, 0);
        for (int i = 0; i < 5; i++) send_word(REQ_SRC, $urandom_range(0, 255), 0, 0);
        for (int i = 0; i < 12; i++) send_word(REQ_PIX, $urandom_range(0, 255), 0, 0);
        send_word(REQ_TICK, 0, 0, 0);
        calm = 1'b0;

        // Random small frames with random content, up to the item goal.
        lim = ITEM_GOAL;
        while (sent < lim) begin
            set_all($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 8),
                    $urandom_range(1, 8), $urandom_range(0, 1), $urandom_range(0, 255));
            calm = ($urandom_range(0, 3) == 0);
            for (int r = $urandom_range(2, 10); r > 0; r--) begin
                if (sent >= lim) break;
                gen_row(1'b1);
                // At random, the sender pauses until every owed result has come back.
                if ($urandom_range(0, 7) == 0)
                    while (word_q.size() != 0 || owed_q.size() != 0) @(negedge i_clk);
            end
        end

        wait_idle();
        if (!failed) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== nearest_neighbor_keyed_scale_blit.f =====
hdl/nnksb_pkg.sv
hdl/nnksb_if.sv
hdl/nnksb_front.sv
hdl/nnksb_div.sv
hdl/nnksb_back.sv
hdl/nearest_neighbor_keyed_scale_blit.sv
test/tb_nearest_neighbor_keyed_scale_blit.sv
